// ===== rtl/hcbd_pkg.sv =====
// Shared types, codes and helpers of the chunked body decoder.
`timescale 1ns / 1ps

package hcbd_pkg;

    // Default width of the chunk size and remaining byte counters.
    localparam int SIZE_BITS_DEF = 32;

    // Decoder phases.
    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_SIZE_CR = 3'd1,
        PH_DATA    = 3'd2,
        PH_TRAIL1  = 3'd3,
        PH_TRAIL2  = 3'd4,
        PH_DONE    = 3'd5
    } t_phase;

    // Status codes carried on the closing result.
    localparam logic [1:0] ST_ZERO_CHUNK = 2'd0;
    localparam logic [1:0] ST_TRUNCATED  = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW   = 2'd3;

    // Characters of interest in a size line.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // One result item as it travels from the core to the output buffer.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_payload;
        logic       is_last;
        logic [1:0] status;
    } t_result;

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b1, c[3:0]};
            end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
                r = {1'b1, c[3:0] + 4'd9};
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/hcbd_if.sv =====
// Valid/ready stream interfaces for the body input and the decoded output.
`timescale 1ns / 1ps

interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_body;

    modport source (output valid, output data_byte, output end_of_body, input ready);
    modport sink   (input valid, input data_byte, input end_of_body, output ready);
endinterface

interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       has_payload;
    logic       is_last;
    logic [1:0] status;

    modport source (output valid, output payload_byte, output has_payload,
                    output is_last, output status, input ready);
    modport sink   (input valid, input payload_byte, input has_payload,
                    input is_last, input status, output ready);
endinterface

// ===== rtl/hcbd_core.sv =====
// Chunk framing state machine: consumes one byte per transfer and forms its result.
`timescale 1ns / 1ps

module hcbd_core
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_body,
    output logic       o_result_valid,
    output t_result    o_result
);

    t_phase                 r_phase, n_phase;
    logic [SIZE_BITS-1:0]   r_size_value, n_size_value;
    logic                   r_digits_seen, n_digits_seen;
    logic                   r_digits_ended, n_digits_ended;
    logic [SIZE_BITS-1:0]   r_bytes_left, n_bytes_left;

    logic [4:0]           hex;
    logic                 is_cr, is_lf, is_blank;
    logic                 in_done, overflow, line_done, close_bad, close_zero;
    logic                 close_now, data_out;
    logic [1:0]           close_status;
    logic [SIZE_BITS-1:0] bytes_dec;

    assign hex       = hex_decode(i_data_byte);
    assign is_cr     = (i_data_byte == CH_CR);
    assign is_lf     = (i_data_byte == CH_LF);
    assign is_blank  = (i_data_byte == CH_SPACE) || (i_data_byte == CH_TAB);
    assign in_done   = !(r_phase == PH_SIZE || r_phase == PH_SIZE_CR || r_phase == PH_DATA ||
                         r_phase == PH_TRAIL1 || r_phase == PH_TRAIL2);

    // A further digit would shift set bits out of the top nibble.
    assign overflow  = (r_phase == PH_SIZE) && !is_cr && !r_digits_ended && hex[4] &&
                       (r_size_value[SIZE_BITS-1 -: 4] != 4'd0);
    assign line_done  = (r_phase == PH_SIZE_CR) && is_lf;
    assign close_bad  = line_done && !r_digits_seen;
    assign close_zero = line_done && r_digits_seen && (r_size_value == '0);
    assign close_now  = overflow || close_bad || close_zero;
    assign close_status = overflow ? ST_OVERFLOW : (close_bad ? ST_BAD_SIZE : ST_ZERO_CHUNK);
    assign data_out   = (r_phase == PH_DATA) && (r_bytes_left != '0);
    assign bytes_dec  = data_out ? (r_bytes_left - 1'b1) : r_bytes_left;

    // Next state.
    always_comb begin
        n_phase        = r_phase;
        n_size_value   = r_size_value;
        n_digits_seen  = r_digits_seen;
        n_digits_ended = r_digits_ended;
        n_bytes_left   = r_bytes_left;

        unique case (r_phase)
            PH_SIZE: begin
                if (is_cr) begin
                    n_digits_ended = 1'b1;
                    n_phase        = PH_SIZE_CR;
                end else if (!r_digits_ended && hex[4]) begin
                    if (!overflow) begin
                        n_size_value  = {r_size_value[SIZE_BITS-5:0], hex[3:0]};
                        n_digits_seen = 1'b1;
                    end
                end else if (!r_digits_seen && !r_digits_ended && is_blank) begin
                    n_digits_ended = 1'b0;
                end else begin
                    n_digits_ended = 1'b1;
                end
            end
            PH_SIZE_CR: begin
                if (line_done) begin
                    if (!close_now) begin
                        n_bytes_left = r_size_value;
                        n_phase      = PH_DATA;
                    end
                end else if (!is_cr) begin
                    n_phase = PH_SIZE;
                end
            end
            PH_DATA: begin
                n_bytes_left = bytes_dec;
                if (bytes_dec == '0) begin
                    n_phase = PH_TRAIL1;
                end
            end
            PH_TRAIL1: begin
                n_phase = PH_TRAIL2;
            end
            PH_TRAIL2: begin
                n_size_value   = '0;
                n_digits_seen  = 1'b0;
                n_digits_ended = 1'b0;
                n_phase        = PH_SIZE;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (close_now) begin
            n_phase = PH_DONE;
        end

        // The final byte of a body always brings the decoder back to its reset state.
        if (i_end_of_body) begin
            n_phase        = PH_SIZE;
            n_size_value   = '0;
            n_digits_seen  = 1'b0;
            n_digits_ended = 1'b0;
            n_bytes_left   = '0;
        end
    end

    // Result of the current byte.
    always_comb begin
        o_result.has_payload  = !in_done && data_out;
        o_result.payload_byte = o_result.has_payload ? i_data_byte : 8'd0;
        o_result.is_last      = !in_done && (close_now || i_end_of_body);
        o_result.status       = !o_result.is_last ? ST_ZERO_CHUNK :
                                (close_now ? close_status : ST_TRUNCATED);
        o_result_valid        = o_result.has_payload || o_result.is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SIZE;
            r_size_value   <= '0;
            r_digits_seen  <= 1'b0;
            r_digits_ended <= 1'b0;
            r_bytes_left   <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_size_value   <= n_size_value;
            r_digits_seen  <= n_digits_seen;
            r_digits_ended <= n_digits_ended;
            r_bytes_left   <= n_bytes_left;
        end
    end

endmodule

// ===== rtl/hcbd_skid.sv =====
// Output register with a skid stage so the input side keeps flowing during short stalls.
`timescale 1ns / 1ps

module hcbd_skid
    import hcbd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_data,
    output logic    o_push_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out_data, r_skid_data;
    logic    out_free;

    assign out_free     = !r_out_valid || i_ready;
    assign o_push_ready = !r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_data       = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // The skid entry is older than anything pushed now, so it goes out first.
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_push_data;
        end
        if (!out_free && i_push) begin
            r_skid_data <= i_push_data;
        end
    end

endmodule

// ===== rtl/http_chunked_body_decoder.sv =====
// Top level of the HTTP chunked body decoder.
`timescale 1ns / 1ps
//
//  Channel   Direction  Payload                                      Transfer when
//  i_in      in         data_byte[7:0], end_of_body                  valid && ready
//  o_out     out        payload_byte[7:0], has_payload, is_last,     valid && ready
//                       status[1:0]
//
// One byte is taken every clock cycle while i_in.ready is high. A result is
// registered in the output register, or in the skid stage if o_out stalls,
// before o_out shows it. Reset is synchronous and active low and brings the
// decoder to the start of a size line with an empty output buffer. When o_out
// stalls, one further result fits in the skid stage; after that i_in.ready
// drops until the output drains.

module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hcbd_in_if.sink           i_in,
    hcbd_out_if.source        o_out
);

    logic    accept;
    logic    push_ready;
    logic    result_valid;
    t_result result;
    t_result out_data;

    // A byte is taken only while the skid stage has room for its possible result.
    assign i_in.ready = push_ready;
    assign accept     = i_in.valid && push_ready;

    hcbd_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_in.data_byte),
        .i_end_of_body  (i_in.end_of_body),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    // Bytes that produce no result (size lines, trailers, ignored tail) are
    // consumed without touching the output side.
    hcbd_skid u_skid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (accept && result_valid),
        .i_push_data  (result),
        .o_push_ready (push_ready),
        .o_valid      (o_out.valid),
        .o_data       (out_data),
        .i_ready      (o_out.ready)
    );

    assign o_out.payload_byte = out_data.payload_byte;
    assign o_out.has_payload  = out_data.has_payload;
    assign o_out.is_last      = out_data.is_last;
    assign o_out.status       = out_data.status;

endmodule

// ===== rtl/hcbd_checker.sv =====
// Port-level assertions for the chunked body decoder, bound to the top level.
`timescale 1ns / 1ps

module hcbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_payload_byte,
    input logic       i_has_payload,
    input logic       i_is_last,
    input logic [1:0] i_status
);

    // Coming out of reset the output is empty and input is taken.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("output not empty or input blocked after reset");

    // Every result carries a byte or closes the body.
    a_result_meaningful: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_has_payload || i_is_last))
        else $error("result with neither payload nor close");

    // Status and payload byte are zero where they carry no meaning.
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_is_last || i_status == 2'd0) &&
                         (i_has_payload || i_payload_byte == 8'd0)))
        else $error("unused result field not zero");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_payload_byte) && $stable(i_has_payload) &&
             $stable(i_is_last) && $stable(i_status)))
        else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_payload_byte (o_out.payload_byte),
    .i_has_payload  (o_out.has_payload),
    .i_is_last      (o_out.is_last),
    .i_status       (o_out.status)
);
